### design/dsf_pkg.sv
// dsf_pkg: shared types and constants of the damped spring force block
// depends on nothing; used by damped_spring_force and dsf_force
package dsf_pkg;

   // fixed-point field widths
   localparam int COORD_W = 32;
   localparam int COEF_W  = 31;
   localparam int FORCE_W = 48;
   localparam int DELTA_W = COORD_W + 1;
   localparam int LEN_W   = 34;
   localparam int QUOT_W  = 31;
   localparam int RAD_W   = 2 * LEN_W;
   localparam int EXT_W   = LEN_W + 1;
   localparam int MIN_W   = 16;

   // minimum distance after reset, about 0.001 in Q16.16
   localparam logic [MIN_W-1:0] MIN_DIST_RESET = 16'd66;

   // request word
   typedef struct packed {
      logic signed [COORD_W-1:0] spring_pos_x;
      logic signed [COORD_W-1:0] spring_pos_y;
      logic signed [COORD_W-1:0] spring_pos_z;
      logic signed [COORD_W-1:0] anchor_pos_x;
      logic signed [COORD_W-1:0] anchor_pos_y;
      logic signed [COORD_W-1:0] anchor_pos_z;
      logic signed [COORD_W-1:0] vel_x;
      logic signed [COORD_W-1:0] vel_y;
      logic signed [COORD_W-1:0] vel_z;
      logic        [COEF_W-1:0]  spring_stiffness;
      logic        [COEF_W-1:0]  damping_coeff;
      logic        [COEF_W-1:0]  natural_length;
   } req_type;

   // response word
   typedef struct packed {
      logic signed [FORCE_W-1:0] force_x;
      logic signed [FORCE_W-1:0] force_y;
      logic signed [FORCE_W-1:0] force_z;
      logic                      force_valid;
      logic                      saturated;
   } rsp_type;

endpackage

### design/damped_spring_force.sv
// damped_spring_force: top level, front end, square root and division lanes
// depends on dsf_pkg, dsf_delay, dsf_sqrt, dsf_div, dsf_force
//
// usage
//   req channel (req_valid/req_ready/req_data) takes one spring word per
//   cycle; rsp channel (rsp_valid/rsp_ready/rsp_data) returns one force word
//   per spring in the same order. csr_we/csr_wdata write min_distance; write
//   it only while no word is in flight.
//   from acceptance to rsp_valid a word passes 3 front stages, 34 root
//   stages, 31 divider and 7 force stages; throughput one word per cycle
//   when unstalled, set by the one-bit-per-stage root and divider pipelines.
//   when the receiver holds rsp_ready low with a word waiting, the whole
//   pipeline freezes and req_ready drops; nothing is lost or repeated.
//   bubbles in flight still hold their place.
//   reset (synchronous, active high) empties the pipeline and sets
//   min_distance to 66 (about 0.001); there is no clearing pass.
//   a spring shorter than min_distance, or of zero length, returns a zero
//   force with force_valid low.
module damped_spring_force (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dsf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dsf_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [dsf_pkg::MIN_W-1:0] csr_wdata
);

   localparam int CW     = dsf_pkg::COORD_W;
   localparam int KW     = dsf_pkg::COEF_W;
   localparam int DW     = dsf_pkg::DELTA_W;
   localparam int LW     = dsf_pkg::LEN_W;
   localparam int RW     = dsf_pkg::RAD_W;
   localparam int QW     = dsf_pkg::QUOT_W;
   localparam int EW     = dsf_pkg::EXT_W;
   localparam int SIDE_W = 3 * CW + 3 * KW;
   localparam int SQ_SB_W  = 3 * DW + SIDE_W;
   localparam int DIV_SB_W = 3 + 3 * CW + 2 * KW + EW + 1;

   logic en;
   logic rsp_valid_w;

   // pipeline advances unless a finished word is stuck at the output
   assign en        = !rsp_valid_w || rsp_ready;
   assign req_ready = en;

   // min distance register
   logic [dsf_pkg::MIN_W-1:0] min_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= dsf_pkg::MIN_DIST_RESET;
      end else if (csr_we) begin
         min_dist_ff <= csr_wdata;
      end
   end

   // request fields as per-axis arrays
   logic signed [CW-1:0] spos [3];
   logic signed [CW-1:0] apos [3];
   logic [SIDE_W-1:0]    side0;

   assign spos[0] = req_data.spring_pos_x;
   assign spos[1] = req_data.spring_pos_y;
   assign spos[2] = req_data.spring_pos_z;
   assign apos[0] = req_data.anchor_pos_x;
   assign apos[1] = req_data.anchor_pos_y;
   assign apos[2] = req_data.anchor_pos_z;
   assign side0 = {req_data.vel_x, req_data.vel_y, req_data.vel_z,
                   req_data.spring_stiffness, req_data.damping_coeff,
                   req_data.natural_length};

   // stage 1: delta = anchor - spring
   logic                 v1_ff, v2_ff, v3_ff;
   logic signed [DW-1:0] d1_ff [3];
   logic [SIDE_W-1:0]    side1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d1_ff[i] <= {apos[i][CW-1], apos[i]} - {spos[i][CW-1], spos[i]};
         end
         side1_ff <= side0;
      end
   end

   // stage 2: squared magnitudes
   logic [DW-1:0]        dmag1 [3];
   logic [2*DW-1:0]      sq2_ff [3];
   logic signed [DW-1:0] d2_ff [3];
   logic [SIDE_W-1:0]    side2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dmag1[i] = d1_ff[i][DW-1] ? DW'(~d1_ff[i] + 1'b1) : DW'(d1_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq2_ff[i] <= {{DW{1'b0}}, dmag1[i]} * {{DW{1'b0}}, dmag1[i]};
            d2_ff[i]  <= d1_ff[i];
         end
         side2_ff <= side1_ff;
      end
   end

   // stage 3: sum of squares
   logic [RW-1:0]        s3_ff;
   logic signed [DW-1:0] d3_ff [3];
   logic [SIDE_W-1:0]    side3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff    <= RW'(sq2_ff[0]) + RW'(sq2_ff[1]) + RW'(sq2_ff[2]);
         d3_ff    <= d2_ff;
         side3_ff <= side2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // length by square root, side data delayed alongside
   logic [LW-1:0]        len;
   logic                 va_valid;
   logic [SQ_SB_W-1:0]   sq_sb;
   logic signed [DW-1:0] da [3];
   logic signed [CW-1:0] vela [3];
   logic [KW-1:0]        stiff_a, damp_a, rest_a;

   dsf_sqrt #(.RAD_W(RW)) u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (s3_ff),
      .root  (len)
   );

   dsf_delay #(.W(SQ_SB_W), .D(LW)) u_sq_dly (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_data   ({d3_ff[0], d3_ff[1], d3_ff[2], side3_ff}),
      .out_valid (va_valid),
      .out_data  (sq_sb)
   );

   assign {da[0], da[1], da[2], vela[0], vela[1], vela[2], stiff_a, damp_a, rest_a} = sq_sb;

   // extension and short-spring check
   logic signed [EW-1:0] ext_a;
   logic                 short_a;
   logic [DW-1:0]        dmag_a [3];
   logic [2:0]           dneg_a;

   always_comb begin
      ext_a   = $signed({1'b0, len}) - $signed({4'b0, rest_a});
      short_a = (len == '0) || (len < {(LW-dsf_pkg::MIN_W)'(0), min_dist_ff});
      for (int i = 0; i < 3; i++) begin
         dmag_a[i] = da[i][DW-1] ? DW'(~da[i] + 1'b1) : DW'(da[i]);
         dneg_a[i] = da[i][DW-1];
      end
   end

   // direction lanes
   logic [QW-1:0] quot [3];

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_div
         dsf_div #(.MAG_W(DW), .DEN_W(LW), .Q_W(QW)) u_div (
            .clock (clock),
            .en    (en),
            .mag   (dmag_a[g]),
            .den   (len),
            .quot  (quot[g])
         );
      end
   endgenerate

   logic                 vb_valid;
   logic [DIV_SB_W-1:0]  div_sb;
   logic [2:0]           dneg_b;
   logic signed [CW-1:0] velb [3];
   logic [KW-1:0]        stiff_b, damp_b;
   logic signed [EW-1:0] ext_b;
   logic                 short_b;

   dsf_delay #(.W(DIV_SB_W), .D(QW)) u_div_dly (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (va_valid),
      .in_data   ({dneg_a, vela[0], vela[1], vela[2], stiff_a, damp_a, ext_a, short_a}),
      .out_valid (vb_valid),
      .out_data  (div_sb)
   );

   assign {dneg_b, velb[0], velb[1], velb[2], stiff_b, damp_b, ext_b, short_b} = div_sb;

   // force back end and output register
   dsf_force u_force (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vb_valid),
      .quot      (quot),
      .dneg      (dneg_b),
      .vel       (velb),
      .stiff     (stiff_b),
      .damp      (damp_b),
      .ext       (ext_b),
      .short_len (short_b),
      .rsp_valid (rsp_valid_w),
      .rsp_data  (rsp_data)
   );

   assign rsp_valid = rsp_valid_w;

`ifndef SYNTHESIS
   // input side only stalls when a result is held at the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low without an output stall");

   // short springs return an all-zero word
   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.force_valid) |->
         (rsp_data.force_x == '0 && rsp_data.force_y == '0 &&
          rsp_data.force_z == '0 && !rsp_data.saturated))
      else $error("short spring result not zero");

   // a stalled output word does not move while the pipeline is frozen
   a_frozen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data) && $stable(va_valid)))
      else $error("pipeline moved during a stall");
`endif

endmodule

### design/dsf_delay.sv
// dsf_delay: enabled shift line that carries a valid bit and side data
// depends on nothing
module dsf_delay #(
   parameter int W = 8,
   parameter int D = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   output logic [W-1:0] out_data
);

   logic         valid_ff [D];
   logic [W-1:0] data_ff  [D];

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < D; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < D; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   // data chain
   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= in_data;
         for (int i = 1; i < D; i++) data_ff[i] <= data_ff[i-1];
      end
   end

   assign out_valid = valid_ff[D-1];
   assign out_data  = data_ff[D-1];

endmodule

### design/dsf_sqrt.sv
// dsf_sqrt: pipelined floor square root, one root bit per stage
// depends on nothing
module dsf_sqrt #(
   parameter int RAD_W = 68
) (
   input  logic               clock,
   input  logic               en,
   input  logic [RAD_W-1:0]   rad,
   output logic [RAD_W/2-1:0] root
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 3;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];

   genvar k;
   generate
      for (k = 0; k < ROOT_W; k++) begin : g_stage
         logic [REM_W-1:0]  rem_prev;
         logic [ROOT_W-1:0] root_prev;
         logic [RAD_W-1:0]  rad_prev;
         logic [REM_W-1:0]  rem_t;
         logic [REM_W-1:0]  trial;
         logic [REM_W-1:0]  rem_in;
         logic [ROOT_W-1:0] root_in;

         if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad;
         end else begin : g_next
            assign rem_prev  = rem_ff[k-1];
            assign root_prev = root_ff[k-1];
            assign rad_prev  = rad_ff[k-1];
         end

         // bring down two radicand bits and try root*4+1
         always_comb begin
            rem_t = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
            trial = {{(REM_W-ROOT_W-2){1'b0}}, root_prev, 2'b01};
            if (rem_t >= trial) begin
               rem_in  = rem_t - trial;
               root_in = {root_prev[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_t;
               root_in = {root_prev[ROOT_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= rem_in;
               root_ff[k] <= root_in;
               rad_ff[k]  <= {rad_prev[RAD_W-3:0], 2'b00};
            end
         end
      end
   endgenerate

   assign root = root_ff[ROOT_W-1];

endmodule

### design/dsf_div.sv
// dsf_div: pipelined restoring divider, mag * 2^(Q_W-1) / den, one bit per stage
// depends on nothing; quotient must stay below 2^Q_W (mag <= den)
module dsf_div #(
   parameter int MAG_W = 33,
   parameter int DEN_W = 34,
   parameter int Q_W   = 31
) (
   input  logic             clock,
   input  logic             en,
   input  logic [MAG_W-1:0] mag,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quot
);

   logic [DEN_W-1:0] rem_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0]   q_ff   [Q_W];

   genvar k;
   generate
      for (k = 0; k < Q_W; k++) begin : g_stage
         logic [DEN_W-1:0] rem_prev;
         logic [DEN_W-1:0] den_prev;
         logic [Q_W-1:0]   q_prev;
         logic             bring;
         logic [DEN_W:0]   rem_t;
         logic [DEN_W-1:0] rem_in;
         logic             bit_in;

         if (k == 0) begin : g_first
            // dividend is mag shifted up, so only its low bit comes down here, zeros after
            assign rem_prev = DEN_W'(mag >> 1);
            assign den_prev = den;
            assign q_prev   = '0;
            assign bring    = mag[0];
         end else begin : g_next
            assign rem_prev = rem_ff[k-1];
            assign den_prev = den_ff[k-1];
            assign q_prev   = q_ff[k-1];
            assign bring    = 1'b0;
         end

         // shift in one dividend bit, subtract when it fits
         always_comb begin
            rem_t = {rem_prev, bring};
            if (rem_t >= {1'b0, den_prev}) begin
               rem_in = DEN_W'(rem_t - {1'b0, den_prev});
               bit_in = 1'b1;
            end else begin
               rem_in = rem_t[DEN_W-1:0];
               bit_in = 1'b0;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_prev;
               q_ff[k]   <= {q_prev[Q_W-2:0], bit_in};
            end
         end
      end
   endgenerate

   assign quot = q_ff[Q_W-1];

endmodule

### design/dsf_force.sv
// dsf_force: back end from unit direction to saturated force, seven stages
// depends on dsf_pkg
module dsf_force (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [dsf_pkg::QUOT_W-1:0]     quot [3],
   input  logic [2:0]                     dneg,
   input  logic signed [dsf_pkg::COORD_W-1:0] vel [3],
   input  logic [dsf_pkg::COEF_W-1:0]     stiff,
   input  logic [dsf_pkg::COEF_W-1:0]     damp,
   input  logic signed [dsf_pkg::EXT_W-1:0] ext,
   input  logic                           short_len,
   output logic                           rsp_valid,
   output dsf_pkg::rsp_type               rsp_data
);

   localparam int CW = dsf_pkg::COORD_W;
   localparam int KW = dsf_pkg::COEF_W;
   localparam int QW = dsf_pkg::QUOT_W;
   localparam int FW = dsf_pkg::FORCE_W;
   localparam int TW = FW;
   localparam int SW = FW + 2;
   localparam int EXT_MAG_W = dsf_pkg::LEN_W;

   localparam logic [SW-1:0] NEG_MAX = SW'(1) << (FW - 1);
   localparam logic [SW-1:0] POS_MAX = NEG_MAX - SW'(1);

   // valid chain
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;

   // stage 1: signed direction and spring term
   logic signed [CW-1:0] dir1_ff [3];
   logic [QW-1:0]        dmag1_ff [3];
   logic [TW-1:0]        sprod1_ff;
   logic                 eneg1_ff;
   logic signed [CW-1:0] vel1_ff [3];
   logic [KW-1:0]        damp1_ff;
   logic                 short1_ff;
   logic [EXT_MAG_W-1:0] ext_mag;
   logic [63+1:0]        sp_full;

   always_comb begin
      ext_mag = ext[dsf_pkg::EXT_W-1] ? EXT_MAG_W'(~ext + 1'b1) : EXT_MAG_W'(ext);
      sp_full = {31'b0, ext_mag} * {34'b0, stiff};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dir1_ff[i]  <= dneg[i] ? -$signed({1'b0, quot[i]}) : $signed({1'b0, quot[i]});
            dmag1_ff[i] <= quot[i];
            vel1_ff[i]  <= vel[i];
         end
         sprod1_ff <= sp_full[63:16];
         eneg1_ff  <= ext[dsf_pkg::EXT_W-1];
         damp1_ff  <= damp;
         short1_ff <= short_len;
      end
   end

   // stage 2: velocity times direction per axis
   logic signed [63:0]   pd2_ff [3];
   logic                 dsgn2_ff [3];
   logic [QW-1:0]        dmag2_ff [3];
   logic [TW-1:0]        sprod2_ff;
   logic                 eneg2_ff;
   logic [KW-1:0]        damp2_ff;
   logic                 short2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pd2_ff[i]   <= 64'(vel1_ff[i]) * 64'(dir1_ff[i]);
            dsgn2_ff[i] <= dir1_ff[i][CW-1];
            dmag2_ff[i] <= dmag1_ff[i];
         end
         sprod2_ff <= sprod1_ff;
         eneg2_ff  <= eneg1_ff;
         damp2_ff  <= damp1_ff;
         short2_ff <= short1_ff;
      end
   end

   // stage 3: dot product and velocity along the axis
   logic signed [63:0] dot;
   logic [63:0]        dot_mag;
   logic [32:0]        va3_ff;
   logic               vneg3_ff;
   logic               dsgn3_ff [3];
   logic [QW-1:0]      dmag3_ff [3];
   logic [TW-1:0]      sprod3_ff;
   logic               eneg3_ff;
   logic [KW-1:0]      damp3_ff;
   logic               short3_ff;

   always_comb begin
      dot     = pd2_ff[0] + pd2_ff[1] + pd2_ff[2];
      dot_mag = dot[63] ? 64'(-dot) : 64'(dot);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         va3_ff    <= dot_mag[62:30];
         vneg3_ff  <= dot[63];
         for (int i = 0; i < 3; i++) begin
            dsgn3_ff[i] <= dsgn2_ff[i];
            dmag3_ff[i] <= dmag2_ff[i];
         end
         sprod3_ff <= sprod2_ff;
         eneg3_ff  <= eneg2_ff;
         damp3_ff  <= damp2_ff;
         short3_ff <= short2_ff;
      end
   end

   // stage 4: damping term
   logic [63:0]   dp_full;
   logic [TW-1:0] dprod4_ff;
   logic          vneg4_ff;
   logic          dsgn4_ff [3];
   logic [QW-1:0] dmag4_ff [3];
   logic [TW-1:0] sprod4_ff;
   logic          eneg4_ff;
   logic          short4_ff;

   assign dp_full = {31'b0, va3_ff} * {33'b0, damp3_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         dprod4_ff <= dp_full[63:16];
         vneg4_ff  <= vneg3_ff;
         for (int i = 0; i < 3; i++) begin
            dsgn4_ff[i] <= dsgn3_ff[i];
            dmag4_ff[i] <= dmag3_ff[i];
         end
         sprod4_ff <= sprod3_ff;
         eneg4_ff  <= eneg3_ff;
         short4_ff <= short3_ff;
      end
   end

   // stage 5: scalar = spring term - damping term
   logic signed [SW-1:0] sp_s, dp_s, scalar;
   logic [SW-2:0]        smag5_ff;
   logic                 sneg5_ff;
   logic                 dsgn5_ff [3];
   logic [QW-1:0]        dmag5_ff [3];
   logic                 short5_ff;

   always_comb begin
      sp_s   = eneg4_ff ? -$signed({2'b0, sprod4_ff}) : $signed({2'b0, sprod4_ff});
      dp_s   = vneg4_ff ? -$signed({2'b0, dprod4_ff}) : $signed({2'b0, dprod4_ff});
      scalar = sp_s - dp_s;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         smag5_ff  <= scalar[SW-1] ? (SW-1)'(-scalar) : (SW-1)'(scalar);
         sneg5_ff  <= scalar[SW-1];
         for (int i = 0; i < 3; i++) begin
            dsgn5_ff[i] <= dsgn4_ff[i];
            dmag5_ff[i] <= dmag4_ff[i];
         end
         short5_ff <= short4_ff;
      end
   end

   // stage 6: direction times scalar, split in low and high partial products
   logic [QW+31:0]    plo6_ff [3];
   logic [QW+SW-34:0] phi6_ff [3];
   logic              neg6_ff [3];
   logic              short6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            plo6_ff[i] <= {32'b0, dmag5_ff[i]} * {31'b0, smag5_ff[31:0]};
            phi6_ff[i] <= {(SW-33)'(0), dmag5_ff[i]} * {QW'(0), smag5_ff[SW-2:32]};
            neg6_ff[i] <= dsgn5_ff[i] ^ sneg5_ff;
         end
         short6_ff <= short5_ff;
      end
   end

   // stage 7: sum partials, scale down, saturate
   logic                 rsp_valid_ff;
   dsf_pkg::rsp_type     rsp_data_ff;
   logic [79:0]          full [3];
   logic [SW-1:0]        fm   [3];
   logic signed [FW-1:0] fo   [3];
   logic [2:0]           clamp;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         full[i] = {phi6_ff[i], 32'b0} + {17'b0, plo6_ff[i]};
         fm[i]   = full[i][79:30];
         clamp[i] = 1'b0;
         if (neg6_ff[i] && fm[i] > NEG_MAX) begin
            fm[i]    = NEG_MAX;
            clamp[i] = 1'b1;
         end else if (!neg6_ff[i] && fm[i] > POS_MAX) begin
            fm[i]    = POS_MAX;
            clamp[i] = 1'b1;
         end
         fo[i] = neg6_ff[i] ? -$signed(fm[i][FW-1:0]) : $signed(fm[i][FW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (short6_ff) begin
            rsp_data_ff <= '0;
         end else begin
            rsp_data_ff.force_x     <= fo[0];
            rsp_data_ff.force_y     <= fo[1];
            rsp_data_ff.force_z     <= fo[2];
            rsp_data_ff.force_valid <= 1'b1;
            rsp_data_ff.saturated   <= |clamp;
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         rsp_valid_ff <= v6_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
